[hdl/http_request_line_splitter_assert.svh]
// ----------------------------------------------------------------------------
// HTTP request line splitter assertion macros
// Shared property macros for the concurrent checks of the splitter.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_SPLITTER_ASSERT_SVH
`define HTTP_REQUEST_LINE_SPLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRLS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrls check failed");

// The consequent must hold in the cycle after the antecedent.
`define HRLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrls check failed");

`endif

[hdl/hrls_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP request line splitter package
// Types, character codes and default sizes shared by the splitter modules.
// ----------------------------------------------------------------------------
package hrls_pkg;

  // Width of every reported offset and length.
  localparam int OUT_W = 13;

  // Default limit on the number of bytes examined in one buffer.
  localparam int MAX_BYTES_DEF = 4096;

  // Character codes the parser looks for.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  // Parser phases, in the order they are entered.
  typedef enum logic [2:0] {
    PH_METHOD,
    PH_GAP1,
    PH_URL,
    PH_GAP2,
    PH_VERSION,
    PH_EOL,
    PH_DONE
  } hrls_phase_e;

  // One result item.
  typedef struct packed {
    logic             line_valid;
    logic [OUT_W-1:0] method_length;
    logic [OUT_W-1:0] url_start;
    logic [OUT_W-1:0] url_length;
    logic [OUT_W-1:0] version_start;
    logic [OUT_W-1:0] version_length;
    logic [OUT_W-1:0] consumed_length;
    logic             too_long;
  } hrls_result_t;

endpackage

[hdl/hrls_parser.sv]
// ----------------------------------------------------------------------------
// HTTP request line splitter parser
// Phase machine and span registers; takes one registered byte per cycle while
// step_valid_i is high and forms the result on the last byte of a buffer.
// ----------------------------------------------------------------------------
module hrls_parser #(
  parameter int MAX_BYTES = hrls_pkg::MAX_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_valid_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  res_fire_o,
  output hrls_pkg::hrls_result_t res_o
);

  localparam int PW = $clog2(MAX_BYTES + 1);
  localparam int EW = (PW > hrls_pkg::OUT_W) ? PW : hrls_pkg::OUT_W;

  // Reduce a position-wide value to the reported width.
  function automatic logic [hrls_pkg::OUT_W-1:0] to_out(input logic [PW-1:0] v);
    logic [EW-1:0] w;
    w = EW'(v);
    return w[hrls_pkg::OUT_W-1:0];
  endfunction

  hrls_pkg::hrls_phase_e phase_q, phase_d, ph_take;
  logic [PW-1:0] pos_q, pos_d, pos_t;
  logic [PW-1:0] mlen_q, mlen_d, mlen_t, mlen_f;
  logic [PW-1:0] ustart_q, ustart_d, ustart_t, ustart_f;
  logic [PW-1:0] ulen_q, ulen_d, ulen_t, ulen_f;
  logic [PW-1:0] vstart_q, vstart_d, vstart_t, vstart_f;
  logic [PW-1:0] vlen_q, vlen_d, vlen_t, vlen_f;
  logic [PW-1:0] cons_q, cons_d, cons_t, cons_f;
  logic          ovf_q, ovf_d, ovf_t;
  logic          at_limit, take, is_sp, is_eol, done;

  assign at_limit = (pos_q >= PW'(MAX_BYTES));
  assign take     = step_valid_i && !at_limit;
  assign is_sp    = (data_byte_i == hrls_pkg::CHAR_SPACE);
  assign is_eol   = (data_byte_i == hrls_pkg::CHAR_CR) || (data_byte_i == hrls_pkg::CHAR_LF);
  assign done     = step_valid_i && last_byte_i;

  // Next phase after examining the byte.
  always_comb begin
    ph_take = phase_q;
    if (take) begin
      case (phase_q)
        hrls_pkg::PH_METHOD:  if (is_sp) ph_take = hrls_pkg::PH_GAP1;
        hrls_pkg::PH_GAP1:    if (!is_sp) ph_take = hrls_pkg::PH_URL;
        hrls_pkg::PH_URL:     if (is_sp) ph_take = hrls_pkg::PH_GAP2;
        hrls_pkg::PH_GAP2: begin
          if (!is_sp) ph_take = is_eol ? hrls_pkg::PH_EOL : hrls_pkg::PH_VERSION;
        end
        hrls_pkg::PH_VERSION: if (is_eol) ph_take = hrls_pkg::PH_EOL;
        hrls_pkg::PH_EOL:     if (!is_eol) ph_take = hrls_pkg::PH_DONE;
        default:              ph_take = phase_q;
      endcase
    end
    phase_d = done ? hrls_pkg::PH_METHOD : ph_take;
  end

  // Span updates for the byte at the current position.
  always_comb begin
    pos_t    = pos_q;
    mlen_t   = mlen_q;
    ustart_t = ustart_q;
    ulen_t   = ulen_q;
    vstart_t = vstart_q;
    vlen_t   = vlen_q;
    cons_t   = cons_q;
    ovf_t    = ovf_q;
    if (step_valid_i && at_limit) begin
      ovf_t = 1'b1;
    end
    if (take) begin
      pos_t = pos_q + PW'(1);
      case (phase_q)
        hrls_pkg::PH_METHOD:  if (is_sp) mlen_t = pos_q;
        hrls_pkg::PH_GAP1:    if (!is_sp) ustart_t = pos_q;
        hrls_pkg::PH_URL:     if (is_sp) ulen_t = pos_q - ustart_q;
        hrls_pkg::PH_GAP2: begin
          if (!is_sp) begin
            vstart_t = pos_q;
            if (is_eol) begin
              vlen_t = '0;
              cons_t = pos_q + PW'(1);
            end
          end
        end
        hrls_pkg::PH_VERSION: begin
          if (is_eol) begin
            vlen_t = pos_q - vstart_q;
            cons_t = pos_q + PW'(1);
          end
        end
        hrls_pkg::PH_EOL:     if (is_eol) cons_t = pos_q + PW'(1);
        default:              cons_t = cons_q;
      endcase
    end
  end

  // Close any part still open when the buffer ends.
  always_comb begin
    mlen_f   = mlen_t;
    ustart_f = ustart_t;
    ulen_f   = ulen_t;
    vstart_f = vstart_t;
    vlen_f   = vlen_t;
    cons_f   = cons_t;
    case (ph_take)
      hrls_pkg::PH_METHOD: begin
        mlen_f   = pos_t;
        ustart_f = pos_t;
        ulen_f   = '0;
        vstart_f = pos_t;
        vlen_f   = '0;
        cons_f   = pos_t;
      end
      hrls_pkg::PH_GAP1: begin
        ustart_f = pos_t;
        ulen_f   = '0;
        vstart_f = pos_t;
        vlen_f   = '0;
        cons_f   = pos_t;
      end
      hrls_pkg::PH_URL: begin
        ulen_f   = pos_t - ustart_t;
        vstart_f = pos_t;
        vlen_f   = '0;
        cons_f   = pos_t;
      end
      hrls_pkg::PH_GAP2: begin
        vstart_f = pos_t;
        vlen_f   = '0;
        cons_f   = pos_t;
      end
      hrls_pkg::PH_VERSION: begin
        vlen_f = pos_t - vstart_t;
        cons_f = pos_t;
      end
      default: cons_f = cons_t;
    endcase
  end

  // Result item and register next values; a finished buffer clears the state.
  always_comb begin
    res_o.line_valid      = (|mlen_f) && (|ulen_f) && (|vlen_f) && !ovf_t;
    res_o.method_length   = to_out(mlen_f);
    res_o.url_start       = to_out(ustart_f);
    res_o.url_length      = to_out(ulen_f);
    res_o.version_start   = to_out(vstart_f);
    res_o.version_length  = to_out(vlen_f);
    res_o.consumed_length = to_out(cons_f);
    res_o.too_long        = ovf_t;
    if (done) begin
      pos_d    = '0;
      mlen_d   = '0;
      ustart_d = '0;
      ulen_d   = '0;
      vstart_d = '0;
      vlen_d   = '0;
      cons_d   = '0;
      ovf_d    = 1'b0;
    end else begin
      pos_d    = pos_t;
      mlen_d   = mlen_t;
      ustart_d = ustart_t;
      ulen_d   = ulen_t;
      vstart_d = vstart_t;
      vlen_d   = vlen_t;
      cons_d   = cons_t;
      ovf_d    = ovf_t;
    end
  end

  assign res_fire_o = done;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hrls_pkg::PH_METHOD;
      pos_q    <= '0;
      mlen_q   <= '0;
      ustart_q <= '0;
      ulen_q   <= '0;
      vstart_q <= '0;
      vlen_q   <= '0;
      cons_q   <= '0;
      ovf_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      mlen_q   <= mlen_d;
      ustart_q <= ustart_d;
      ulen_q   <= ulen_d;
      vstart_q <= vstart_d;
      vlen_q   <= vlen_d;
      cons_q   <= cons_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

[hdl/hrls_out_stage.sv]
// ----------------------------------------------------------------------------
// HTTP request line splitter output stage
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module hrls_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  hrls_pkg::hrls_result_t res_i,
  output logic                   can_load_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output hrls_pkg::hrls_result_t res_o
);

  logic                   valid_q, valid_d;
  hrls_pkg::hrls_result_t res_q;

  // The register may take a new item when empty or when it empties this cycle.
  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[hdl/http_request_line_splitter.sv]
// ----------------------------------------------------------------------------
// HTTP request line splitter
// Splits a request line, presented one byte per item, into method, URL and
// version spans. The block accepts one byte every clock cycle unless the
// input stalls: a byte is captured in the input register, examined by the
// phase machine once it moves on from there, and on the byte marked last the
// result item is written to the output register, from which it is presented.
// Input stalls only while a last byte waits for a full output register that
// the consumer has not yet taken. No reset sweep is needed.
// ----------------------------------------------------------------------------
`include "http_request_line_splitter_assert.svh"

module http_request_line_splitter #(
  parameter int MAX_BYTES = hrls_pkg::MAX_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        line_valid_o,
  output logic [hrls_pkg::OUT_W-1:0]  method_length_o,
  output logic [hrls_pkg::OUT_W-1:0]  url_start_o,
  output logic [hrls_pkg::OUT_W-1:0]  url_length_o,
  output logic [hrls_pkg::OUT_W-1:0]  version_start_o,
  output logic [hrls_pkg::OUT_W-1:0]  version_length_o,
  output logic [hrls_pkg::OUT_W-1:0]  consumed_length_o,
  output logic                        too_long_o
);

  logic                   s1_valid_q, s1_valid_d;
  logic [7:0]             s1_byte_q;
  logic                   s1_last_q;
  logic                   s1_advance, in_take;
  logic                   res_fire, out_can_load;
  hrls_pkg::hrls_result_t res_comb, res_out;

  // The held item moves on unless it is a last byte facing a blocked output.
  assign s1_advance = s1_valid_q && (!s1_last_q || out_can_load);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Phase machine and spans.
  hrls_parser #(
    .MAX_BYTES (MAX_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (s1_advance),
    .data_byte_i  (s1_byte_q),
    .last_byte_i  (s1_last_q),
    .res_fire_o   (res_fire),
    .res_o        (res_comb)
  );

  // Result register.
  hrls_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_fire),
    .res_i      (res_comb),
    .can_load_o (out_can_load),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .res_o      (res_out)
  );

  assign line_valid_o      = res_out.line_valid;
  assign method_length_o   = res_out.method_length;
  assign url_start_o       = res_out.url_start;
  assign url_length_o      = res_out.url_length;
  assign version_start_o   = res_out.version_start;
  assign version_length_o  = res_out.version_length;
  assign consumed_length_o = res_out.consumed_length;
  assign too_long_o        = res_out.too_long;

  // A result is only formed when the output register can take it.
  `HRLS_ASSERT_SAME(a_fire_has_room, clk_i, rst_ni, res_fire, out_can_load)
  // A last byte blocked by the output holds the input side off.
  `HRLS_ASSERT_SAME(a_stall_blocks_input, clk_i, rst_ni,
                    s1_valid_q && s1_last_q && out_valid_o && !out_ready_i, !in_ready_o)
  // An overlong buffer never reports a valid line.
  `HRLS_ASSERT_SAME(a_too_long_invalid, clk_i, rst_ni, out_valid_o && too_long_o, !line_valid_o)
  // A formed result is presented in the following cycle.
  `HRLS_ASSERT_NEXT(a_fire_shows, clk_i, rst_ni, res_fire, out_valid_o)

endmodule

[test/http_line_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request line checker
// Watches both item channels of the request line splitter. It tracks the
// parser phase and the span registers byte by byte, queues the result item
// expected for each buffer, and compares every result item taken from the
// splitter with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module http_line_checker #(
  parameter int MAX_BYTES = hrls_pkg::MAX_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        line_valid_i,
  input  logic [hrls_pkg::OUT_W-1:0]  method_length_i,
  input  logic [hrls_pkg::OUT_W-1:0]  url_start_i,
  input  logic [hrls_pkg::OUT_W-1:0]  url_length_i,
  input  logic [hrls_pkg::OUT_W-1:0]  version_start_i,
  input  logic [hrls_pkg::OUT_W-1:0]  version_length_i,
  input  logic [hrls_pkg::OUT_W-1:0]  consumed_length_i,
  input  logic                        too_long_i,
  output int                          mismatch_count_o,
  output int                          lines_checked_o,
  output int                          lines_pending_o
);

  import hrls_pkg::*;

  // Tracked parser state for the buffer in flight.
  hrls_phase_e  phase_q;
  int           pos_q;
  int           method_len_q;
  int           url_start_q;
  int           url_len_q;
  int           ver_start_q;
  int           ver_len_q;
  int           consumed_q;
  bit           overflow_q;

  // Result items still owed by the splitter, oldest first.
  hrls_result_t expected_lines[$];
  hrls_result_t want;

  // Return the tracked state to the start of a buffer.
  task automatic clear_line();
    phase_q      = PH_METHOD;
    pos_q        = 0;
    method_len_q = 0;
    url_start_q  = 0;
    url_len_q    = 0;
    ver_start_q  = 0;
    ver_len_q    = 0;
    consumed_q   = 0;
    overflow_q   = 1'b0;
  endtask

  // Advance the phase machine by one accepted byte. On the last byte the
  // open spans are closed at the buffer length and the result is queued.
  task automatic split_byte(input logic [7:0] octet, input logic last_b);
    hrls_result_t res;
    bit           is_sp;
    bit           is_eol;
    int           len;
    is_sp  = (octet == CHAR_SPACE);
    is_eol = (octet == CHAR_CR) || (octet == CHAR_LF);
    if (pos_q >= MAX_BYTES) begin
      overflow_q = 1'b1;
    end else begin
      case (phase_q)
        PH_METHOD: begin
          if (is_sp) begin
            method_len_q = pos_q;
            phase_q      = PH_GAP1;
          end
        end
        PH_GAP1: begin
          if (!is_sp) begin
            url_start_q = pos_q;
            phase_q     = PH_URL;
          end
        end
        PH_URL: begin
          if (is_sp) begin
            url_len_q = pos_q - url_start_q;
            phase_q   = PH_GAP2;
          end
        end
        PH_GAP2: begin
          if (!is_sp) begin
            ver_start_q = pos_q;
            if (is_eol) begin
              // The version is empty.
              ver_len_q  = 0;
              consumed_q = pos_q + 1;
              phase_q    = PH_EOL;
            end else begin
              phase_q = PH_VERSION;
            end
          end
        end
        PH_VERSION: begin
          if (is_eol) begin
            ver_len_q  = pos_q - ver_start_q;
            consumed_q = pos_q + 1;
            phase_q    = PH_EOL;
          end
        end
        PH_EOL: begin
          if (is_eol) begin
            consumed_q = pos_q + 1;
          end else begin
            phase_q = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      pos_q++;
    end

    if (last_b) begin
      // Parts not reached start at the buffer length; an open part ends there.
      len = pos_q;
      if (phase_q == PH_METHOD) method_len_q = len;
      if (phase_q <= PH_GAP1) begin
        url_start_q = len;
        url_len_q   = 0;
      end
      if (phase_q == PH_URL) url_len_q = len - url_start_q;
      if (phase_q <= PH_GAP2) begin
        ver_start_q = len;
        ver_len_q   = 0;
      end
      if (phase_q == PH_VERSION) ver_len_q = len - ver_start_q;
      if (phase_q <= PH_VERSION) consumed_q = len;

      res.line_valid      = (method_len_q > 0) && (url_len_q > 0) && (ver_len_q > 0)
                            && !overflow_q;
      res.method_length   = OUT_W'(method_len_q);
      res.url_start       = OUT_W'(url_start_q);
      res.url_length      = OUT_W'(url_len_q);
      res.version_start   = OUT_W'(ver_start_q);
      res.version_length  = OUT_W'(ver_len_q);
      res.consumed_length = OUT_W'(consumed_q);
      res.too_long        = overflow_q;
      expected_lines.push_back(res);
      clear_line();
    end
  endtask

  // Compare one field and count a mismatch.
  task automatic check_field(input string name, input logic [OUT_W-1:0] exp_v,
                             input logic [OUT_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatch_count_o++;
    end
  endtask

  // Output items are compared before the input byte of the same edge is
  // tracked, so the oldest expectation is always the one compared.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      expected_lines.delete();
      mismatch_count_o = 0;
      lines_checked_o  = 0;
      lines_pending_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_lines.size() == 0) begin
          $error("result item taken with no result expected");
          mismatch_count_o++;
        end else begin
          want = expected_lines.pop_front();
          check_field("line_valid", OUT_W'(want.line_valid), OUT_W'(line_valid_i));
          check_field("method_length", want.method_length, method_length_i);
          check_field("url_start", want.url_start, url_start_i);
          check_field("url_length", want.url_length, url_length_i);
          check_field("version_start", want.version_start, version_start_i);
          check_field("version_length", want.version_length, version_length_i);
          check_field("consumed_length", want.consumed_length, consumed_length_i);
          check_field("too_long", OUT_W'(want.too_long), OUT_W'(too_long_i));
          lines_checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        split_byte(data_byte_i, last_byte_i);
      end
      lines_pending_o = expected_lines.size();
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request line splitter testbench
// Feeds short directed request lines and then random lines, mostly well
// formed with random content and the rest truncated or noise. Both sides idle
// in random bursts, and once the consumer holds off long enough for the
// splitter to stall its input. A checker beside the splitter predicts and
// compares every result item.
// ----------------------------------------------------------------------------
module tb_top;

  import hrls_pkg::*;

  localparam int MAX_BYTES    = MAX_BYTES_DEF;
  localparam int RANDOM_ITEMS = 1020;
  localparam int CYCLE_LIMIT  = 800_000;
  localparam int LONG_HOLD    = 400;

  typedef logic [7:0] octet_q_t[$];

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          data_byte_i;
  logic                last_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                line_valid_o;
  logic [OUT_W-1:0]    method_length_o;
  logic [OUT_W-1:0]    url_start_o;
  logic [OUT_W-1:0]    url_length_o;
  logic [OUT_W-1:0]    version_start_o;
  logic [OUT_W-1:0]    version_length_o;
  logic [OUT_W-1:0]    consumed_length_o;
  logic                too_long_o;

  int                  mismatch_count;
  int                  lines_checked;
  int                  lines_pending;
  int                  items_sent;
  int                  lines_sent;
  int                  cycles;
  bit                  gappy;
  bit                  calm;
  bit                  hold_req;

  http_request_line_splitter #(
    .MAX_BYTES (MAX_BYTES)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .line_valid_o      (line_valid_o),
    .method_length_o   (method_length_o),
    .url_start_o       (url_start_o),
    .url_length_o      (url_length_o),
    .version_start_o   (version_start_o),
    .version_length_o  (version_length_o),
    .consumed_length_o (consumed_length_o),
    .too_long_o        (too_long_o)
  );

  http_line_checker #(
    .MAX_BYTES (MAX_BYTES)
  ) line_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .line_valid_i      (line_valid_o),
    .method_length_i   (method_length_o),
    .url_start_i       (url_start_o),
    .url_length_i      (url_length_o),
    .version_start_i   (version_start_o),
    .version_length_i  (version_length_o),
    .consumed_length_i (consumed_length_o),
    .too_long_i        (too_long_o),
    .mismatch_count_o  (mismatch_count),
    .lines_checked_o   (lines_checked),
    .lines_pending_o   (lines_pending)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Random byte, optionally never a space and never CR or LF.
  function automatic logic [7:0] pick_byte(input bit no_space, input bit no_eol);
    logic [7:0] octet;
    octet = 8'($urandom_range(0, 255));
    while ((no_space && octet == CHAR_SPACE) ||
           (no_eol && (octet == CHAR_CR || octet == CHAR_LF))) begin
      octet = 8'($urandom_range(0, 255));
    end
    return octet;
  endfunction

  // Offer one item and hold it until it is accepted, after an optional gap.
  task automatic send_byte(input logic [7:0] octet, input logic last_b);
    if (gappy && !calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= octet;
    last_byte_i <= last_b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Send one buffer, marking its final byte as last.
  task automatic send_octets(input octet_q_t text);
    gappy = ($urandom_range(0, 1) == 1);
    foreach (text[i]) begin
      send_byte(text[i], i == text.size() - 1);
    end
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    octet_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_octets(text);
  endtask

  // Mostly well-formed lines with random content; some cut short, some noise.
  task automatic send_random_line();
    octet_q_t text;
    int       kind;
    int       cut;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      repeat ($urandom_range(1, 6)) text.push_back(pick_byte(1'b1, 1'b0));
      repeat ($urandom_range(1, 3)) text.push_back(CHAR_SPACE);
      repeat ($urandom_range(1, 12)) text.push_back(pick_byte(1'b1, 1'b0));
      repeat ($urandom_range(1, 3)) text.push_back(CHAR_SPACE);
      // An empty version means the line break follows the spaces at once.
      repeat ($urandom_range(0, 8)) text.push_back(pick_byte(1'b1, 1'b1));
      repeat ($urandom_range(1, 3)) begin
        text.push_back(($urandom_range(0, 1) == 1) ? CHAR_CR : CHAR_LF);
      end
      repeat ($urandom_range(0, 4)) text.push_back(pick_byte(1'b0, 1'b0));
      if (kind >= 6) begin
        cut = $urandom_range(1, text.size());
        while (text.size() > cut) text.delete(text.size() - 1);
      end
    end else begin
      repeat ($urandom_range(1, 24)) begin
        case ($urandom_range(0, 3))
          0:       text.push_back(CHAR_SPACE);
          1:       text.push_back(CHAR_CR);
          2:       text.push_back(CHAR_LF);
          default: text.push_back(pick_byte(1'b0, 1'b0));
        endcase
      end
    end
    send_octets(text);
  endtask

  // Consumer: random stall bursts, one long hold-off, none in the last part.
  initial begin
    int stall_left;
    bit long_done;
    stall_left  = 0;
    long_done   = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req && !long_done) begin
        long_done  = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Reset, stimulus and verdict.
  initial begin
    octet_q_t text;
    int       first_item;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= 8'h00;
    last_byte_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines: buffers ending in each phase, an empty version, a
    // trailing break run followed by ignored bytes, and the byte extremes.
    send_text("\377");
    send_text("A ");
    text = {CHAR_SPACE, 8'h00, CHAR_SPACE, CHAR_SPACE, CHAR_LF};
    send_octets(text);
    send_text("G /");
    send_text("G / ");
    send_text("G / H");
    send_text("G  / H\r\n\rZ\n");

    // Random lines; the consumer holds off once near the start.
    hold_req   <= 1'b1;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (items_sent - first_item > RANDOM_ITEMS * 85 / 100) calm = 1'b1;
      send_random_line();
    end
    in_valid_i <= 1'b0;

    // Drain, then allow time for any stray result item.
    while (lines_pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d bytes in %0d buffers, with buffers ending in every phase.",
             items_sent, lines_sent);
    $display("Compared %0d result items, %0d mismatches.", lines_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/hrls_pkg.sv
hdl/hrls_parser.sv
hdl/hrls_out_stage.sv
hdl/http_request_line_splitter.sv
test/http_line_checker.sv
test/tb_top.sv
